[rtl/spq_pkg.sv]
package spq_pkg;

  // Queue geometry.
  localparam int unsigned NUM_CLASSES = 3;
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned LEN_BITS    = 14;

  // Derived widths.
  localparam int unsigned HEAD_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W   = HEAD_W + 1;
  localparam int unsigned ADDR_W  = $clog2(NUM_CLASSES * QUEUE_DEPTH);
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned WORD_W  = TAG_W + LEN_BITS;
  localparam int unsigned TOTAL_W = $clog2(NUM_CLASSES * QUEUE_DEPTH) + LEN_BITS + 1;

  // Event codes.
  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_PAUSE   = 2'd1;
  localparam logic [1:0] ACT_DONE    = 2'd2;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;

  // Class codes.
  localparam logic [1:0] CLASS_LOW  = 2'd0;
  localparam logic [1:0] CLASS_MID  = 2'd1;
  localparam logic [1:0] CLASS_HIGH = 2'd2;
  localparam logic [1:0] CLASS_NONE = 2'd3;

  // Send state codes.
  localparam logic [1:0] ST_READY    = 2'd0;
  localparam logic [1:0] ST_PAUSE_RX = 2'd1;
  localparam logic [1:0] ST_PAUSED   = 2'd2;

  // Highest class whose FIFO holds a packet, or none.
  function automatic logic [1:0] highest_class(logic [NUM_CLASSES-1:0] nonempty);
    logic [1:0] cls;
    priority if (nonempty[2]) begin
      cls = CLASS_HIGH;
    end else if (nonempty[1]) begin
      cls = CLASS_MID;
    end else if (nonempty[0]) begin
      cls = CLASS_LOW;
    end else begin
      cls = CLASS_NONE;
    end
    return cls;
  endfunction

endpackage

[rtl/strict_priority_queue_with_pause.sv]
// The result of an input transfer is held in the output register in the cycle after it.
// Throughput: one event per cycle while the result side takes every result; a waiting
// result is held and the next event is taken in the same cycle the result transfers.
// The rate is set by the single-port packet store, one write or one read per event.
// Reset (asynchronous, active low) empties all FIFOs, clears the byte total, sets the
// served class to none and the send state to ready; the packet store is not cleared.
module strict_priority_queue_with_pause
  import spq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [1:0]  prio_i,
  input  logic [13:0] pkt_len_i,
  input  logic [15:0] pkt_tag_i,
  input  logic [15:0] pause_quanta_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        depart_valid_o,
  output logic [15:0] depart_tag_o,
  output logic [13:0] depart_len_o,
  output logic [1:0]  depart_prio_o,
  output logic [1:0]  serving_class_o,
  output logic [1:0]  send_state_o,
  output logic [21:0] backlog_bytes_o,
  output logic        drop_flag_o,
  output logic        error_flag_o
);

  // Queue control state. Per-class head index and packet count live in flops; the
  // packets themselves live in one shared store, one region of QUEUE_DEPTH words per
  // class.
  logic [HEAD_W-1:0] head_q [NUM_CLASSES];
  logic [HEAD_W-1:0] head_d [NUM_CLASSES];
  logic [CNT_W-1:0]  cnt_q  [NUM_CLASSES];
  logic [CNT_W-1:0]  cnt_d  [NUM_CLASSES];
  logic [1:0]        served_q, served_d;
  logic [1:0]        state_q, state_d;

  // The byte total still includes the length of the packet popped by the last
  // accepted event, because that length only arrives from the store's registered read word.
  // It is taken off when the next event is accepted, and the backlog output subtracts
  // it on the fly until then.
  logic [TOTAL_W-1:0] total_q, total_d;

  logic [WORD_W-1:0] store_mem [NUM_CLASSES * QUEUE_DEPTH];
  logic [WORD_W-1:0] rd_word_q;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic              wr_en, pop;

  // Output register.
  logic       out_valid_q;
  logic       dv_q;
  logic [1:0] dprio_q;
  logic       drop_q, err_q;

  logic                   in_xfer;
  logic [LEN_BITS-1:0]    len_in;
  logic [LEN_BITS-1:0]    rd_len;
  logic [NUM_CLASSES-1:0] nonempty_q, nonempty_d;
  logic                   drop, err;
  logic [SUM_W-1:0]       tail_sum;
  logic [HEAD_W-1:0]      tail_pos;
  logic [HEAD_W-1:0]      next_head;

  // A new event is taken whenever the output register is empty or drains this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign len_in = LEN_BITS'(pkt_len_i);
  assign rd_len = rd_word_q[LEN_BITS-1:0];

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      nonempty_q[c] = (cnt_q[c] != '0);
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_d[c] = head_q[c];
      cnt_d[c]  = cnt_q[c];
    end
    served_d   = served_q;
    state_d    = state_q;
    total_d    = total_q - (dv_q ? TOTAL_W'(rd_len) : '0);
    nonempty_d = nonempty_q;
    wr_en      = 1'b0;
    pop        = 1'b0;
    drop       = 1'b0;
    err        = 1'b0;
    wr_addr    = '0;
    rd_addr    = '0;
    tail_sum   = '0;
    tail_pos   = '0;
    next_head  = '0;

    unique case (action_i)
      ACT_ENQUEUE: begin
        if (prio_i == CLASS_NONE) begin
          drop = 1'b1;
        end else if (cnt_q[prio_i] >= CNT_W'(QUEUE_DEPTH)) begin
          drop = 1'b1;
        end else begin
          tail_sum = SUM_W'(head_q[prio_i]) + SUM_W'(cnt_q[prio_i]);
          tail_pos = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : HEAD_W'(tail_sum);
          wr_en    = 1'b1;
          wr_addr  = ADDR_W'(prio_i) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_pos);
          cnt_d[prio_i] = cnt_q[prio_i] + 1'b1;
          total_d  = total_d + TOTAL_W'(len_in);
          // Only the new packet's class holds anything when the queue was empty.
          if ((nonempty_q == '0) && (state_q == ST_READY)) begin
            served_d = prio_i;
          end
        end
      end
      ACT_PAUSE: begin
        if ((pause_quanta_i != '0) && (state_q == ST_READY)) begin
          state_d = (nonempty_q != '0) ? ST_PAUSE_RX : ST_PAUSED;
        end else if (state_q != ST_READY) begin
          // Any pause frame that arrives while not ready resumes sending.
          state_d = ST_READY;
          if (nonempty_q != '0) begin
            served_d = highest_class(nonempty_q);
          end
        end
      end
      ACT_DONE: begin
        if (served_q == CLASS_NONE) begin
          err = 1'b1;
        end else if (cnt_q[served_q] == '0) begin
          err = 1'b1;
        end else begin
          pop       = 1'b1;
          rd_addr   = ADDR_W'(served_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[served_q]);
          next_head = (head_q[served_q] == HEAD_W'(QUEUE_DEPTH - 1)) ?
                      '0 : head_q[served_q] + 1'b1;
          head_d[served_q] = next_head;
          cnt_d[served_q]  = cnt_q[served_q] - 1'b1;
        end
        // Occupancy after the pop decides the new selection.
        for (int c = 0; c < NUM_CLASSES; c++) begin
          nonempty_d[c] = (cnt_d[c] != '0);
        end
        if (state_q == ST_PAUSE_RX) begin
          state_d = ST_PAUSED;
        end
        if (nonempty_d != '0) begin
          if (state_d == ST_READY) begin
            served_d = highest_class(nonempty_d);
          end
        end else begin
          served_d = CLASS_NONE;
        end
      end
      default: begin
        // The unused code only reports the current status.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c] <= '0;
        cnt_q[c]  <= '0;
      end
      served_q    <= CLASS_NONE;
      state_q     <= ST_READY;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      dv_q        <= 1'b0;
      dprio_q     <= CLASS_LOW;
      drop_q      <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      if (in_xfer) begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          head_q[c] <= head_d[c];
          cnt_q[c]  <= cnt_d[c];
        end
        served_q    <= served_d;
        state_q     <= state_d;
        total_q     <= total_d;
        out_valid_q <= 1'b1;
        dv_q        <= pop;
        dprio_q     <= pop ? served_q : CLASS_LOW;
        drop_q      <= drop;
        err_q       <= err;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Packet store: one write for an enqueue or one read for a pop per accepted event.
  // The read word is held until the next pop, so it stays valid while the result waits.
  always_ff @(posedge clk_i) begin
    if (in_xfer && wr_en) begin
      store_mem[wr_addr] <= {pkt_tag_i, len_in};
    end
    if (in_xfer && pop) begin
      rd_word_q <= store_mem[rd_addr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign depart_valid_o  = dv_q;
  assign depart_tag_o    = dv_q ? rd_word_q[WORD_W-1:LEN_BITS] : '0;
  assign depart_len_o    = dv_q ? 14'(rd_len) : '0;
  assign depart_prio_o   = dprio_q;
  assign serving_class_o = served_q;
  assign send_state_o    = state_q;
  assign backlog_bytes_o = 22'(total_q - (dv_q ? TOTAL_W'(rd_len) : '0));
  assign drop_flag_o     = drop_q;
  assign error_flag_o    = err_q;

endmodule
